### hdl/lzwd_pkg.sv
package lzwd_pkg;

	// default width of the length register and of the consumed count
	localparam int LenBitsDef = 16;

	localparam int ByteW   = 8;
	localparam int WinAw   = 8;
	localparam int WinDepth = 1 << WinAw;
	localparam int TokW    = 13;
	localparam int HeldW   = 4;
	localparam int CntW    = 5;

	localparam logic [ByteW-1:0] WinFill    = 8'h20;
	localparam logic [WinAw-1:0] WriteStart = 8'hEF;
	localparam logic [HeldW-1:0] LitHeld    = 4'd9;
	localparam logic [HeldW-1:0] CopyHeld   = 4'd13;
	localparam logic [CntW-1:0]  CopyBias   = 5'd2;
	localparam int               RoundBias  = 6;

	// bit stream from the input shifter to the token engine
	typedef struct packed {
		logic vld;
		logic dat;
	} lzwd_bit_t;

	// engine status seen by the input shifter
	typedef struct packed {
		logic drop;
		logic busy;
		logic halt;
	} lzwd_stat_t;

	typedef enum logic [1:0] {
		ENG_TOKEN,
		ENG_READ,
		ENG_EMIT
	} lzwd_state_t;

endpackage

### hdl/lzwd_ram.sv
module lzwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/lzwd_bit_feed.sv
module lzwd_bit_feed (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  logic [7:0]         in_byte,
	input  lzwd_pkg::lzwd_stat_t stat,
	input  logic               take,
	output lzwd_pkg::lzwd_bit_t  bits
);

	import lzwd_pkg::*;

	logic [ByteW-1:0] sh_q;
	logic [3:0]       cnt_q;
	logic             xfer;

	assign src_stall = (cnt_q != 4'd0) || stat.busy;
	assign xfer      = src_valid && !src_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 4'd0;
		end else if (stat.halt) begin
			cnt_q <= 4'd0;
		end else if (xfer) begin
			// ignored bytes are taken but never shifted out to the engine
			if (!stat.drop) begin
				cnt_q <= 4'(ByteW);
			end
		end else if (take) begin
			cnt_q <= cnt_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			sh_q <= in_byte;
		end else if (take) begin
			sh_q <= {sh_q[ByteW-2:0], 1'b0};
		end
	end

	assign bits.vld = (cnt_q != 4'd0) && !stat.halt;
	assign bits.dat = sh_q[ByteW-1];

endmodule

### hdl/lzwd_engine.sv
module lzwd_engine #(
	parameter int LENGTH_BITS = lzwd_pkg::LenBitsDef
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lzwd_pkg::lzwd_bit_t    bits,
	output logic                   take,
	output lzwd_pkg::lzwd_stat_t   stat,
	input  logic [LENGTH_BITS-1:0] decoded_length,
	output logic                   dec_valid,
	input  logic                   dec_stall,
	output logic [7:0]             out_byte,
	output logic                   last,
	output logic [LENGTH_BITS-1:0] consumed_bytes
);

	import lzwd_pkg::*;

	localparam int UsedW = LENGTH_BITS + 4;
	localparam int QW    = UsedW - 2;
	localparam logic [UsedW-1:0] UsedMax = {UsedW{1'b1}};

	lzwd_state_t state_q, state_d;

	logic [TokW-1:0]        tok_q;
	logic [HeldW-1:0]       held_q;
	logic [UsedW-1:0]       used_q;
	logic [LENGTH_BITS-1:0] prod_q;
	logic                   fin_q;
	logic [WinAw-1:0]       wp_q;
	logic [WinAw-1:0]       rd_addr_q;
	logic [CntW-1:0]        cnt_q;
	logic [WinDepth-1:0]    wvld_q;
	logic                   rvld_q;
	logic                   out_valid_q;
	logic [ByteW-1:0]       out_byte_q;
	logic                   last_q;
	logic [LENGTH_BITS-1:0] cons_q;

	logic [TokW-1:0]        nt;
	logic [HeldW-1:0]       held_n;
	logic [UsedW-1:0]       used_n;
	logic [UsedW-1:0]       used_cur;
	logic [UsedW:0]         used_sum;
	logic [QW-1:0]          used_q8;
	logic [LENGTH_BITS-1:0] cons_sat;
	logic [LENGTH_BITS-1:0] prod_n;
	logic                   last_n;
	logic                   can_emit;
	logic                   lit;
	logic                   cpy;
	logic                   emit_en;
	logic [ByteW-1:0]       emit_dat;
	logic                   ram_re;
	logic [ByteW-1:0]       ram_rdata;

	assign can_emit = !out_valid_q || !dec_stall;
	assign take     = (state_q == ENG_TOKEN) && bits.vld && !fin_q && can_emit;

	assign nt     = {tok_q[TokW-2:0], bits.dat};
	assign held_n = held_q + 4'd1;
	assign used_n = (used_q == UsedMax) ? used_q : used_q + UsedW'(1);
	assign lit    = take && (held_n == LitHeld) && nt[ByteW];
	assign cpy    = take && (held_n == CopyHeld);

	assign prod_n = prod_q + LENGTH_BITS'(1);
	assign last_n = (prod_n == decoded_length);

	// consumed count: (bits used + 6) / 8, saturated
	assign used_cur = take ? used_n : used_q;
	assign used_sum = {1'b0, used_cur} + (UsedW + 1)'(RoundBias);
	assign used_q8  = used_sum[UsedW:3];
	assign cons_sat = (used_q8[QW-1:LENGTH_BITS] != 2'b00) ? {LENGTH_BITS{1'b1}}
		: used_q8[LENGTH_BITS-1:0];

	assign stat.drop = fin_q || (prod_q >= decoded_length);
	assign stat.busy = (state_q != ENG_TOKEN);
	assign stat.halt = fin_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ENG_TOKEN: begin
				if (cpy) begin
					state_d = ENG_READ;
				end
			end
			ENG_READ: begin
				state_d = ENG_EMIT;
			end
			ENG_EMIT: begin
				if (can_emit) begin
					if (cnt_q == CntW'(1) || last_n) begin
						state_d = ENG_TOKEN;
					end else begin
						state_d = ENG_READ;
					end
				end
			end
			default: begin
				state_d = ENG_TOKEN;
			end
		endcase
	end

	always_comb begin
		emit_en  = 1'b0;
		emit_dat = nt[ByteW-1:0];
		ram_re   = 1'b0;
		unique case (state_q)
			ENG_TOKEN: begin
				emit_en = lit;
			end
			ENG_READ: begin
				ram_re = 1'b1;
			end
			ENG_EMIT: begin
				emit_en  = can_emit;
				emit_dat = rvld_q ? ram_rdata : WinFill;
			end
			default: begin
				emit_en = 1'b0;
			end
		endcase
	end

	lzwd_ram #(
		.WIDTH(ByteW),
		.DEPTH(WinDepth)
	) u_win (
		.clk  (clk),
		.we   (emit_en),
		.waddr(wp_q),
		.wdata(emit_dat),
		.re   (ram_re),
		.raddr(rd_addr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ENG_TOKEN;
			tok_q       <= '0;
			held_q      <= '0;
			used_q      <= '0;
			prod_q      <= '0;
			fin_q       <= 1'b0;
			wp_q        <= WriteStart;
			cnt_q       <= '0;
			wvld_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				used_q <= used_n;
				if (lit || cpy) begin
					tok_q  <= '0;
					held_q <= '0;
				end else begin
					tok_q  <= nt;
					held_q <= held_n;
				end
			end
			if (cpy) begin
				cnt_q <= {1'b0, nt[3:0]} + CopyBias;
			end else if (state_q == ENG_EMIT && can_emit) begin
				cnt_q <= cnt_q - CntW'(1);
			end
			if (emit_en) begin
				wp_q         <= wp_q + WinAw'(1);
				wvld_q[wp_q] <= 1'b1;
				prod_q       <= prod_n;
				out_valid_q  <= 1'b1;
				if (last_n) begin
					fin_q <= 1'b1;
				end
			end else if (!dec_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cpy) begin
			rd_addr_q <= nt[11:4];
		end else if (state_q == ENG_EMIT && can_emit) begin
			rd_addr_q <= rd_addr_q + WinAw'(1);
		end
		if (ram_re) begin
			rvld_q <= wvld_q[rd_addr_q];
		end
		if (emit_en) begin
			out_byte_q <= emit_dat;
			last_q     <= last_n;
			cons_q     <= last_n ? cons_sat : '0;
		end
	end

	assign dec_valid      = out_valid_q;
	assign out_byte       = out_byte_q;
	assign last           = last_q;
	assign consumed_bytes = cons_q;

endmodule

### hdl/lzss_window_decoder.sv
// channel | handshake              | payload
// src     | src_valid / src_stall  | in_byte
// dec     | dec_valid / dec_stall  | out_byte, last, consumed_bytes
// cfg     | cfg_we (no stall)      | cfg_data -> decoded_length
//
// each accepted byte is loaded into the shifter, then shifted out one bit at a time as the engine takes it
// for each copied byte a copy token does a window read, then an emit
// arst_n clears control state; the window reads as 0x20 until written
// a stall on dec while a result is held freezes both the bit shifter and the copy sequence
// a byte that arrives after the length is reached is taken and ignored
module lzss_window_decoder #(
	parameter int LENGTH_BITS = lzwd_pkg::LenBitsDef
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_we,
	input  logic [LENGTH_BITS-1:0] cfg_data,
	// compressed byte stream
	input  logic                   src_valid,
	output logic                   src_stall,
	input  logic [7:0]             in_byte,
	// decoded byte stream
	output logic                   dec_valid,
	input  logic                   dec_stall,
	output logic [7:0]             out_byte,
	output logic                   last,
	output logic [LENGTH_BITS-1:0] consumed_bytes
);

	import lzwd_pkg::*;

	logic [LENGTH_BITS-1:0] len_q;
	lzwd_bit_t              bits;
	lzwd_stat_t             stat;
	logic                   take;

	// length register, takes effect at once and clears nothing else
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cfg_we) begin
			len_q <= cfg_data;
		end
	end

	// input byte shifter, one bit per cycle toward the engine while the engine takes bits
	lzwd_bit_feed u_feed (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.in_byte  (in_byte),
		.stat     (stat),
		.take     (take),
		.bits     (bits)
	);

	// token assembly, copy sequencing, window and output register
	lzwd_engine #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_eng (
		.clk           (clk),
		.arst_n        (arst_n),
		.bits          (bits),
		.take          (take),
		.stat          (stat),
		.decoded_length(len_q),
		.dec_valid     (dec_valid),
		.dec_stall     (dec_stall),
		.out_byte      (out_byte),
		.last          (last),
		.consumed_bytes(consumed_bytes)
	);

endmodule

### hdl/lzwd_chk.sv
module lzwd_chk #(
	parameter int LENGTH_BITS = lzwd_pkg::LenBitsDef
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   src_valid,
	input logic                   src_stall,
	input logic                   dec_valid,
	input logic                   dec_stall,
	input logic [7:0]             out_byte,
	input logic                   last,
	input logic [LENGTH_BITS-1:0] consumed_bytes
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && dec_stall |=> dec_valid && $stable(out_byte) && $stable(last))
		else $error("stalled result changed");

	// nothing follows the final byte
	a_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && !dec_stall && last |=> !dec_valid)
		else $error("result after last byte");

	// the consumed count is shown only with the final byte
	a_cons_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && !last |-> consumed_bytes == '0)
		else $error("consumed count without last");

	// handshakes and a valid result are never unknown out of reset
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({src_valid, src_stall, dec_valid})
		&& (!dec_valid || !$isunknown({out_byte, last, consumed_bytes})))
		else $error("unknown value on a port");

endmodule

bind lzss_window_decoder lzwd_chk #(
	.LENGTH_BITS(LENGTH_BITS)
) u_lzwd_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.src_valid     (src_valid),
	.src_stall     (src_stall),
	.dec_valid     (dec_valid),
	.dec_stall     (dec_stall),
	.out_byte      (out_byte),
	.last          (last),
	.consumed_bytes(consumed_bytes)
);
